>>> rtl/prq_pkg.sv
`default_nettype none
package prq_pkg;

   typedef enum logic [2:0] {
      KIND_CONNECT    = 3'd0,
      KIND_DISCONNECT = 3'd1,
      KIND_QUEUE      = 3'd2,
      KIND_CANCEL     = 3'd3,
      KIND_LOCK       = 3'd4,
      KIND_UNLOCK     = 3'd5,
      KIND_DISPATCH   = 3'd6,
      KIND_RELEASE    = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE          = 3'd0,
      ERR_NOT_CONNECTED = 3'd1,
      ERR_CONNECTED     = 3'd2,
      ERR_QUEUED        = 3'd3,
      ERR_LOCKED        = 3'd4,
      ERR_NOT_LOCKED    = 3'd5,
      ERR_NOT_QUEUED    = 3'd6,
      ERR_LOCK_FULL     = 3'd7
   } err_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] user;
      logic [1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [2:0] error_code;
      logic       granted_valid;
      logic [3:0] granted_user;
      logic       holder_valid;
      logic [3:0] holder_user;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/priority_request_queue_with_lock_core.sv
`default_nettype none
// Strict-priority request queue with a lock holder. Each accepted request
// gives exactly one response. Connect, disconnect, lock, unlock and release
// pass through the check, done and output states. Cancel and dispatch search
// the queue memory through its single registered read port with a read and
// a test state per entry, and shift the later entries down with a read and
// a shift state per entry. A queue request from the lock holder shifts its
// priority's entries right from the tail the same way; other queue requests
// append at the tail. Each user has at most one entry queued. The block
// takes one request at a time and is ready again in the same cycle that the
// response is registered. A finished response sits in an output register
// while the next request is accepted and worked, so a stalled response only
// holds the block when the next response is ready.
module priority_request_queue_with_lock_core #(
   parameter int NUM_USERS       = 16,
   parameter int NUM_PRIORITIES  = 3,
   parameter int LOCK_COUNT_BITS = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire prq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output prq_pkg::rsp_type      rsp_data
);

   localparam int UB = (NUM_USERS > 2) ? $clog2(NUM_USERS) : 1;
   localparam int LB = $clog2(NUM_USERS + 1);
   localparam int PB = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
   localparam int DEPTH = NUM_PRIORITIES * NUM_USERS;
   localparam int AB = $clog2(DEPTH);
   localparam int EB = (UB > 4) ? UB : 4;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CHECK = 7'b0000010,
      ST_READ  = 7'b0000100,
      ST_TEST  = 7'b0001000,
      ST_SHIFT = 7'b0010000,
      ST_DONE  = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [NUM_USERS-1:0]       conn_ff, conn_in, qd_ff, qd_in;
   logic [LOCK_COUNT_BITS-1:0] cnt_ff [NUM_USERS];
   logic [LOCK_COUNT_BITS-1:0] cnt_in [NUM_USERS];
   logic [LB-1:0]              len_ff [NUM_PRIORITIES];
   logic [LB-1:0]              len_in [NUM_PRIORITIES];
   logic                       hp_ff, hp_in;
   logic [UB-1:0]              hi_ff, hi_in;

   prq_pkg::req_type req_ff, req_in;
   logic [UB-1:0]    u_ff, u_in;
   logic             ubad_ff, ubad_in;
   logic [PB-1:0]    p_ff, p_in;
   logic [PB-1:0]    sp_ff, sp_in;
   logic [LB-1:0]    pos_ff, pos_in;
   logic             shifting_ff, shifting_in;
   logic             found_ff, found_in;
   logic [UB-1:0]    got_ff, got_in;
   logic [2:0]       err_ff, err_in;
   logic             rv_ff, rv_in;
   prq_pkg::rsp_type rsp_ff, rsp_in;

   logic          wr_en;
   logic [AB-1:0] wr_addr, rd_addr;
   logic [UB-1:0] wr_data, rd_data;

   prq_ram #(.WIDTH(UB), .DEPTH(DEPTH)) u_queue_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   function automatic logic [AB-1:0] addr_of(logic [PB-1:0] p, logic [LB-1:0] i);
      logic [AB+LB-1:0] a;
      a = (AB+LB)'(p) * (AB+LB)'(NUM_USERS) + (AB+LB)'(i);
      return a[AB-1:0];
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   logic req_xfer;
   assign req_xfer = req_valid && !req_stall;

   // Current user's flags.
   logic                       c_conn, c_qd, c_hold;
   logic [LOCK_COUNT_BITS-1:0] c_cnt;
   logic [LB-1:0]              c_len;
   logic                       is_disp, hold_only, match;
   assign c_conn  = conn_ff[u_ff];
   assign c_qd    = qd_ff[u_ff];
   assign c_cnt   = cnt_ff[u_ff];
   assign c_hold  = hp_ff && (hi_ff == u_ff);
   assign c_len   = len_ff[sp_ff];
   assign is_disp = (req_ff.kind == prq_pkg::KIND_DISPATCH);
   assign hold_only = is_disp ? hp_ff : 1'b1;
   assign match   = !hold_only || (rd_data == (is_disp ? hi_ff : u_ff));

   // Sequencer and the shared queue walk.
   always_comb begin
      logic [EB-1:0] uw;
      state_in    = state_ff;
      conn_in     = conn_ff;
      qd_in       = qd_ff;
      cnt_in      = cnt_ff;
      len_in      = len_ff;
      hp_in       = hp_ff;
      hi_in       = hi_ff;
      req_in      = req_ff;
      u_in        = u_ff;
      ubad_in     = ubad_ff;
      p_in        = p_ff;
      sp_in       = sp_ff;
      pos_in      = pos_ff;
      shifting_in = shifting_ff;
      found_in    = found_ff;
      got_in      = got_ff;
      err_in      = err_ff;
      rv_in       = rv_ff && rsp_stall;
      rsp_in      = rsp_ff;
      wr_en       = 1'b0;
      wr_addr     = addr_of(sp_ff, pos_ff);
      wr_data     = rd_data;
      rd_addr     = addr_of(sp_ff, pos_ff);
      uw          = EB'(req_data.user);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               req_in  = req_data;
               u_in    = uw[UB-1:0];
               ubad_in = (32'(req_data.user) >= NUM_USERS);
               p_in    = (32'(req_data.priority_req) >= NUM_PRIORITIES)
                         ? PB'(NUM_PRIORITIES - 1) : PB'(req_data.priority_req);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            err_in   = prq_pkg::ERR_NONE;
            found_in = 1'b0;
            got_in   = '0;
            pos_in   = '0;
            sp_in    = PB'(NUM_PRIORITIES - 1);
            state_in = ST_DONE;
            if (is_disp) begin
               state_in = ST_READ;
            end else if (ubad_ff) begin
               err_in = prq_pkg::ERR_NOT_CONNECTED;
            end else begin
               unique case (prq_pkg::kind_type'(req_ff.kind))
                  prq_pkg::KIND_CONNECT: begin
                     if (c_conn) err_in = prq_pkg::ERR_CONNECTED;
                     else conn_in[u_ff] = 1'b1;
                  end
                  prq_pkg::KIND_DISCONNECT: begin
                     if (!c_conn) err_in = prq_pkg::ERR_NOT_CONNECTED;
                     else if (c_qd) err_in = prq_pkg::ERR_QUEUED;
                     else if (c_cnt != '0) err_in = prq_pkg::ERR_LOCKED;
                     else conn_in[u_ff] = 1'b0;
                  end
                  prq_pkg::KIND_QUEUE: begin
                     sp_in = p_ff;
                     if (!c_conn) err_in = prq_pkg::ERR_NOT_CONNECTED;
                     else if (c_qd) err_in = prq_pkg::ERR_QUEUED;
                     else begin
                        qd_in[u_ff] = 1'b1;
                        // Tail append, or shift right from the tail for the holder.
                        if (len_ff[p_ff] < LB'(NUM_USERS)) begin
                           if (c_hold) begin
                              pos_in = len_ff[p_ff];
                              state_in = (len_ff[p_ff] == '0) ? ST_SHIFT : ST_READ;
                           end else begin
                              wr_en   = 1'b1;
                              wr_addr = addr_of(p_ff, len_ff[p_ff]);
                              wr_data = u_ff;
                              len_in[p_ff] = len_ff[p_ff] + 1'b1;
                           end
                        end
                     end
                  end
                  prq_pkg::KIND_CANCEL: begin
                     if (!c_conn) err_in = prq_pkg::ERR_NOT_CONNECTED;
                     else state_in = ST_READ;
                  end
                  prq_pkg::KIND_LOCK: begin
                     if (!c_conn) err_in = prq_pkg::ERR_NOT_CONNECTED;
                     else if (c_qd) err_in = prq_pkg::ERR_QUEUED;
                     else if (&c_cnt) err_in = prq_pkg::ERR_LOCK_FULL;
                     else cnt_in[u_ff] = c_cnt + 1'b1;
                  end
                  prq_pkg::KIND_UNLOCK: begin
                     if (!c_conn) err_in = prq_pkg::ERR_NOT_CONNECTED;
                     else if (c_qd) err_in = prq_pkg::ERR_QUEUED;
                     else if (c_cnt == '0) err_in = prq_pkg::ERR_NOT_LOCKED;
                     else begin
                        cnt_in[u_ff] = c_cnt - 1'b1;
                        if (c_hold) begin
                           hp_in = 1'b0;
                           hi_in = '0;
                        end
                     end
                  end
                  default: begin
                     if (c_qd) err_in = prq_pkg::ERR_QUEUED;
                     else if (c_cnt != '0) err_in = prq_pkg::ERR_LOCKED;
                     else if (c_conn) err_in = prq_pkg::ERR_CONNECTED;
                  end
               endcase
            end
         end
         ST_READ: begin
            // Holder insert reads entry pos-1; searches read entry pos.
            if (req_ff.kind == prq_pkg::KIND_QUEUE) begin
               rd_addr = addr_of(sp_ff, pos_ff - 1'b1);
               state_in = ST_SHIFT;
            end else if (shifting_ff) begin
               if (pos_ff + 1'b1 >= c_len) begin
                  len_in[sp_ff] = c_len - 1'b1;
                  shifting_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  rd_addr = addr_of(sp_ff, pos_ff + 1'b1);
                  state_in = ST_SHIFT;
               end
            end else if (pos_ff >= c_len) begin
               pos_in = '0;
               if (sp_ff == '0) state_in = ST_DONE;
               else sp_in = sp_ff - 1'b1;
            end else begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (match) begin
               found_in    = 1'b1;
               got_in      = rd_data;
               shifting_in = 1'b1;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
            state_in = ST_READ;
         end
         ST_SHIFT: begin
            wr_en = 1'b1;
            if (req_ff.kind == prq_pkg::KIND_QUEUE) begin
               if (pos_ff == '0) begin
                  wr_data = u_ff;
                  len_in[sp_ff] = c_len + 1'b1;
                  state_in = ST_DONE;
               end else begin
                  pos_in = pos_ff - 1'b1;
                  state_in = (pos_ff == LB'(1)) ? ST_SHIFT : ST_READ;
               end
            end else begin
               pos_in = pos_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (is_disp) begin
               if (found_ff) begin
                  qd_in[got_ff] = 1'b0;
                  if (cnt_ff[got_ff] != '0) begin
                     hp_in = 1'b1;
                     hi_in = got_ff;
                  end
               end
            end else if (req_ff.kind == prq_pkg::KIND_CANCEL &&
                         err_ff == prq_pkg::ERR_NONE) begin
               if (found_ff) qd_in[u_ff] = 1'b0;
               else err_in = prq_pkg::ERR_NOT_QUEUED;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!(rv_ff && rsp_stall)) begin
               rv_in = 1'b1;
               rsp_in.status        = (err_ff != prq_pkg::ERR_NONE);
               rsp_in.error_code    = err_ff;
               rsp_in.granted_valid = is_disp && found_ff;
               rsp_in.granted_user  = (is_disp && found_ff) ? 4'(got_ff) : 4'd0;
               rsp_in.holder_valid  = hp_ff;
               rsp_in.holder_user   = hp_ff ? 4'(hi_ff) : 4'd0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and flag registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         conn_ff     <= '0;
         qd_ff       <= '0;
         hp_ff       <= 1'b0;
         hi_ff       <= '0;
         rv_ff       <= 1'b0;
         shifting_ff <= 1'b0;
         for (int i = 0; i < NUM_USERS; i++) cnt_ff[i] <= '0;
         for (int i = 0; i < NUM_PRIORITIES; i++) len_ff[i] <= '0;
      end else begin
         state_ff    <= state_in;
         conn_ff     <= conn_in;
         qd_ff       <= qd_in;
         hp_ff       <= hp_in;
         hi_ff       <= hi_in;
         rv_ff       <= rv_in;
         shifting_ff <= shifting_in;
         cnt_ff      <= cnt_in;
         len_ff      <= len_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      u_ff     <= u_in;
      ubad_ff  <= ubad_in;
      p_ff     <= p_in;
      sp_ff    <= sp_in;
      pos_ff   <= pos_in;
      found_ff <= found_in;
      got_ff   <= got_in;
      err_ff   <= err_in;
      rsp_ff   <= rsp_in;
   end

   // A response is only raised once its request has reached the output state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_OUT))
      else $error("response without finished request");

   // Status and error code agree.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == (rsp_data.error_code != prq_pkg::ERR_NONE)))
      else $error("status mismatch");

   // A grant only comes with a successful dispatch.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.granted_valid) |-> !rsp_data.status)
      else $error("grant with error");

endmodule
`default_nettype wire

>>> rtl/prq_ram.sv
`default_nettype none
module prq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

   localparam int USERS = 16;
   localparam int PRIOS = 3;
   localparam int LOCK_LIMIT = 255;
   localparam int IDLE_LIMIT = 4000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   prq_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   prq_pkg::rsp_type rsp_data;

   priority_request_queue_with_lock_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Shadow copy of the arbiter state.
   logic       user_connected [USERS];
   logic       user_queued    [USERS];
   int         user_locks     [USERS];
   logic [3:0] prio_queue     [PRIOS][$];
   logic       lock_held;
   logic [3:0] lock_owner;

   prq_pkg::req_type pending_requests [$];
   prq_pkg::rsp_type expected_responses [$];
   int      mismatches = 0;
   int      idle_cycles = 0;
   bit      stimulus_done = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // Remove the first entry (or the first of one user) scanning high priority first.
   function automatic bit take_entry(input bit only_one, input logic [3:0] who,
                                     output logic [3:0] got);
      for (int p = PRIOS - 1; p >= 0; p--) begin
         for (int i = 0; i < prio_queue[p].size(); i++) begin
            if (!only_one || prio_queue[p][i] == who) begin
               got = prio_queue[p][i];
               prio_queue[p].delete(i);
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic prq_pkg::rsp_type predict_arbiter(input prq_pkg::req_type r);
      prq_pkg::rsp_type o;
      prq_pkg::err_type e;
      int               u;
      int               p;
      logic [3:0]       got;
      o = '0;
      e = prq_pkg::ERR_NONE;
      u = r.user;
      p = (r.priority_req >= PRIOS) ? PRIOS - 1 : r.priority_req;
      case (prq_pkg::kind_type'(r.kind))
         prq_pkg::KIND_DISPATCH: begin
            if (take_entry(lock_held, lock_owner, got)) begin
               user_queued[got] = 1'b0;
               o.granted_valid = 1'b1;
               o.granted_user = got;
               if (user_locks[got] > 0) begin
                  lock_held = 1'b1;
                  lock_owner = got;
               end
            end
         end
         prq_pkg::KIND_CONNECT: begin
            if (user_connected[u]) e = prq_pkg::ERR_CONNECTED;
            else user_connected[u] = 1'b1;
         end
         prq_pkg::KIND_DISCONNECT: begin
            if (!user_connected[u]) e = prq_pkg::ERR_NOT_CONNECTED;
            else if (user_queued[u]) e = prq_pkg::ERR_QUEUED;
            else if (user_locks[u] > 0) e = prq_pkg::ERR_LOCKED;
            else user_connected[u] = 1'b0;
         end
         prq_pkg::KIND_QUEUE: begin
            if (!user_connected[u]) e = prq_pkg::ERR_NOT_CONNECTED;
            else if (user_queued[u]) e = prq_pkg::ERR_QUEUED;
            else begin
               if (lock_held && lock_owner == u) prio_queue[p].push_front(u[3:0]);
               else prio_queue[p].push_back(u[3:0]);
               user_queued[u] = 1'b1;
            end
         end
         prq_pkg::KIND_CANCEL: begin
            if (!user_connected[u]) e = prq_pkg::ERR_NOT_CONNECTED;
            else if (!take_entry(1'b1, u[3:0], got)) e = prq_pkg::ERR_NOT_QUEUED;
            else user_queued[u] = 1'b0;
         end
         prq_pkg::KIND_LOCK: begin
            if (!user_connected[u]) e = prq_pkg::ERR_NOT_CONNECTED;
            else if (user_queued[u]) e = prq_pkg::ERR_QUEUED;
            else if (user_locks[u] >= LOCK_LIMIT) e = prq_pkg::ERR_LOCK_FULL;
            else user_locks[u]++;
         end
         prq_pkg::KIND_UNLOCK: begin
            if (!user_connected[u]) e = prq_pkg::ERR_NOT_CONNECTED;
            else if (user_queued[u]) e = prq_pkg::ERR_QUEUED;
            else if (user_locks[u] == 0) e = prq_pkg::ERR_NOT_LOCKED;
            else begin
               user_locks[u]--;
               if (lock_held && lock_owner == u) begin
                  lock_held = 1'b0;
                  lock_owner = '0;
               end
            end
         end
         default: begin
            if (user_queued[u]) e = prq_pkg::ERR_QUEUED;
            else if (user_locks[u] > 0) e = prq_pkg::ERR_LOCKED;
            else if (user_connected[u]) e = prq_pkg::ERR_CONNECTED;
         end
      endcase
      o.error_code = e;
      o.status = (e != prq_pkg::ERR_NONE);
      o.holder_valid = lock_held;
      o.holder_user = lock_held ? lock_owner : 4'd0;
      return o;
   endfunction

   function automatic prq_pkg::req_type make_req(input prq_pkg::kind_type k, input int u,
                                                 input int p);
      prq_pkg::req_type r;
      r.kind = k;
      r.user = u[3:0];
      r.priority_req = p[1:0];
      return r;
   endfunction

   // Acceptance is sampled at the rising edge and used by the driver on the falling edge.
   logic req_taken = 1'b0;
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall)
         expected_responses.push_back(predict_arbiter(req_data));
   end

   // Driver: one request per transfer, with a random gap between requests.
   int req_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               req_data <= pending_requests.pop_front();
               req_valid <= 1'b1;
               req_gap <= $urandom_range(0, 5) * ($urandom_range(0, 3) != 0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall pattern, with stall-free stretches.
   int rsp_hold = 0;
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_hold <= $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: compare each response transfer with the oldest expectation.
   always @(posedge clock) begin
      prq_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_responses.size() == 0) begin
            report("unexpected response", int'(rsp_data), 0);
         end else begin
            want = expected_responses.pop_front();
            if (rsp_data.status != want.status)
               report("status", rsp_data.status, want.status);
            if (rsp_data.error_code != want.error_code)
               report("error_code", rsp_data.error_code, want.error_code);
            if (rsp_data.granted_valid != want.granted_valid)
               report("granted_valid", rsp_data.granted_valid, want.granted_valid);
            if (rsp_data.granted_user != want.granted_user)
               report("granted_user", rsp_data.granted_user, want.granted_user);
            if (rsp_data.holder_valid != want.holder_valid)
               report("holder_valid", rsp_data.holder_valid, want.holder_valid);
            if (rsp_data.holder_user != want.holder_user)
               report("holder_user", rsp_data.holder_user, want.holder_user);
         end
      end
   end

   // Watchdog: fails the run after a long stretch with no transfer while stimulus is pending.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || stimulus_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("priority_request_queue_with_lock_core regression: fail");
         $finish;
      end
   end

   // Build the stimulus: directed cases first, then random requests.
   initial begin
      int               u;
      int               wait_cycles;
      prq_pkg::kind_type k;
      for (int i = 0; i < USERS; i++) begin
         user_connected[i] = 1'b0;
         user_queued[i] = 1'b0;
         user_locks[i] = 0;
      end
      lock_held = 1'b0;
      lock_owner = '0;

      pending_requests.push_back(make_req(prq_pkg::KIND_DISPATCH, 15, 3));
      pending_requests.push_back(make_req(prq_pkg::KIND_QUEUE, 0, 0));
      pending_requests.push_back(make_req(prq_pkg::KIND_CANCEL, 15, 0));
      pending_requests.push_back(make_req(prq_pkg::KIND_RELEASE, 0, 0));
      pending_requests.push_back(make_req(prq_pkg::KIND_CONNECT, 0, 0));
      pending_requests.push_back(make_req(prq_pkg::KIND_CONNECT, 0, 0));
      pending_requests.push_back(make_req(prq_pkg::KIND_CONNECT, 15, 0));
      pending_requests.push_back(make_req(prq_pkg::KIND_UNLOCK, 0, 0));
      pending_requests.push_back(make_req(prq_pkg::KIND_LOCK, 0, 0));
      pending_requests.push_back(make_req(prq_pkg::KIND_RELEASE, 0, 0));
      pending_requests.push_back(make_req(prq_pkg::KIND_DISCONNECT, 0, 0));
      pending_requests.push_back(make_req(prq_pkg::KIND_QUEUE, 15, 0));
      pending_requests.push_back(make_req(prq_pkg::KIND_QUEUE, 0, 3));
      pending_requests.push_back(make_req(prq_pkg::KIND_LOCK, 0, 0));
      pending_requests.push_back(make_req(prq_pkg::KIND_DISCONNECT, 15, 0));
      pending_requests.push_back(make_req(prq_pkg::KIND_CANCEL, 15, 0));
      pending_requests.push_back(make_req(prq_pkg::KIND_DISPATCH, 0, 0));
      pending_requests.push_back(make_req(prq_pkg::KIND_QUEUE, 0, 1));
      pending_requests.push_back(make_req(prq_pkg::KIND_QUEUE, 15, 1));
      pending_requests.push_back(make_req(prq_pkg::KIND_DISPATCH, 9, 2));
      pending_requests.push_back(make_req(prq_pkg::KIND_CANCEL, 0, 0));
      pending_requests.push_back(make_req(prq_pkg::KIND_UNLOCK, 0, 0));
      pending_requests.push_back(make_req(prq_pkg::KIND_DISPATCH, 0, 0));
      pending_requests.push_back(make_req(prq_pkg::KIND_DISPATCH, 0, 0));
      // Saturate one lock count to reach the lock-full case.
      pending_requests.push_back(make_req(prq_pkg::KIND_CONNECT, 7, 0));
      for (int i = 0; i < 256; i++)
         pending_requests.push_back(make_req(prq_pkg::KIND_LOCK, 7, 0));
      for (int i = 0; i < 255; i++)
         pending_requests.push_back(make_req(prq_pkg::KIND_UNLOCK, 7, 0));

      // Random part: queue and dispatch dominate so the queues fill and drain.
      for (int i = 0; i < 760; i++) begin
         u = $urandom_range(0, 15);
         case ($urandom_range(0, 19))
            0, 1:       k = prq_pkg::KIND_CONNECT;
            2:          k = prq_pkg::KIND_DISCONNECT;
            3, 4, 5, 6: k = prq_pkg::KIND_QUEUE;
            7:          k = prq_pkg::KIND_CANCEL;
            8, 9:       k = prq_pkg::KIND_LOCK;
            10, 11:     k = prq_pkg::KIND_UNLOCK;
            12:         k = prq_pkg::KIND_RELEASE;
            default:    k = prq_pkg::KIND_DISPATCH;
         endcase
         pending_requests.push_back(make_req(k, u, $urandom_range(0, 3)));
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (pending_requests.size() == 0 && !req_valid);
      stimulus_done = 1'b1;
      wait_cycles = 0;
      while (expected_responses.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (120) @(posedge clock);
      if (mismatches == 0 && expected_responses.size() == 0)
         $display("priority_request_queue_with_lock_core regression: pass");
      else
         $display("priority_request_queue_with_lock_core regression: fail");
      $finish;
   end
endmodule
`default_nettype wire

>>> filelist.f
rtl/prq_pkg.sv
rtl/prq_ram.sv
rtl/priority_request_queue_with_lock_core.sv
tb/tb_top.sv
